// File: design/rwp_pkg.sv
// Shared types, codes and result builders for the RIFF/WAVE stream parser.
package rwp_pkg;

    localparam logic [1:0] KindSample = 2'd0;
    localparam logic [1:0] KindFormat = 2'd1;
    localparam logic [1:0] KindFinish = 2'd2;
    localparam logic [1:0] KindError  = 2'd3;

    localparam logic [3:0] ErrNoRiff    = 4'd0;
    localparam logic [3:0] ErrNoWave    = 4'd1;
    localparam logic [3:0] ErrFmtShort  = 4'd2;
    localparam logic [3:0] ErrNotPcm    = 4'd3;
    localparam logic [3:0] ErrNot16     = 4'd4;
    localparam logic [3:0] ErrBadFmt    = 4'd5;
    localparam logic [3:0] ErrDataEarly = 4'd6;
    localparam logic [3:0] ErrTruncated = 4'd7;
    localparam logic [3:0] ErrMissing   = 4'd8;

    localparam logic [31:0] TagRiff = 32'h4646_4952;
    localparam logic [31:0] TagWave = 32'h4556_4157;
    localparam logic [31:0] TagFmt  = 32'h2074_6D66;
    localparam logic [31:0] TagData = 32'h6174_6164;
    localparam logic [31:0] FmtMin  = 32'd16;
    localparam logic [15:0] PcmFormat = 16'd1;
    localparam logic [15:0] PcmBits   = 16'd16;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [31:0]        rate;
        logic [15:0]        chans;
        logic [3:0]         err;
        logic               fin;
    } t_result;

    // Up to two results caused by one input byte, in delivery order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_head;

    function automatic t_result mk_error(input logic [3:0] code, input logic fin);
        t_result r;
        r = '0;
        r.kind = KindError;
        r.err  = code;
        r.fin  = fin;
        return r;
    endfunction

    function automatic t_result mk_sample(input logic [15:0] value);
        t_result r;
        r = '0;
        r.kind   = KindSample;
        r.sample = value;
        return r;
    endfunction

    function automatic t_result mk_format(input logic [31:0] rate, input logic [15:0] chans);
        t_result r;
        r = '0;
        r.kind  = KindFormat;
        r.rate  = rate;
        r.chans = chans;
        return r;
    endfunction

    function automatic t_result mk_finish();
        t_result r;
        r = '0;
        r.kind = KindFinish;
        r.fin  = 1'b1;
        return r;
    endfunction

endpackage

// File: design/rwp_in_if.sv
// Byte input channel: valid/ready handshake with one file byte per beat.
interface rwp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;

    modport source(output valid, output data_byte, output is_final, input ready);
    modport sink(input valid, input data_byte, input is_final, output ready);
endinterface

// File: design/rwp_out_if.sv
// Result output channel: valid/ready handshake with one parser event per beat.
interface rwp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic signed [15:0] sample_value;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_total;
    logic [3:0]         error_code;
    logic               final_result;

    modport source(output valid, output event_kind, output sample_value, output rate_hz,
                   output channel_total, output error_code, output final_result,
                   input ready);
    modport sink(input valid, input event_kind, input sample_value, input rate_hz,
                 input channel_total, input error_code, input final_result,
                 output ready);
endinterface

// File: design/rwp_front.sv
// Front end: accepts file bytes, runs the chunk parser and emits result pairs.
module rwp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rwp_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output rwp_pkg::t_pair o_pair
);
    import rwp_pkg::*;

    localparam logic [2:0] PhRiff  = 3'd0;
    localparam logic [2:0] PhRsize = 3'd1;
    localparam logic [2:0] PhWave  = 3'd2;
    localparam logic [2:0] PhId    = 3'd3;
    localparam logic [2:0] PhSize  = 3'd4;
    localparam logic [2:0] PhFmt   = 3'd5;
    localparam logic [2:0] PhSkip  = 3'd6;
    localparam logic [2:0] PhData  = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_field, n_field;
    logic [31:0] r_left, n_left;
    logic [31:0] r_tag, n_tag;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [15:0] r_align, n_align;
    logic        r_fmt_done, n_fmt_done;
    logic        r_any, n_any;
    logic [7:0]  r_low, n_low;
    logic        r_failed, n_failed;
    logic [3:0]  r_pos, n_pos;
    logic [3:0]  r_err, n_err;

    logic        accept;
    t_result     res_c, res_f;
    logic        v_c, v_f;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic [31:0] field;
        logic [31:0] left_dec;
        logic [3:0]  pos_inc;
        logic [15:0] bits_now;
        logic        ok;
        logic [3:0]  end_code;

        n_phase = r_phase;     n_field = r_field;   n_left = r_left;
        n_tag = r_tag;         n_fmt = r_fmt;       n_ch = r_ch;
        n_rate = r_rate;       n_bits = r_bits;     n_align = r_align;
        n_fmt_done = r_fmt_done; n_any = r_any;     n_low = r_low;
        n_failed = r_failed;   n_pos = r_pos;       n_err = r_err;
        res_c = '0; res_f = '0; v_c = 1'b0; v_f = 1'b0;
        ok = 1'b0; end_code = ErrTruncated;

        field    = {i_in.data_byte, r_field[31:8]};
        left_dec = r_left - 32'd1;
        pos_inc  = r_pos + 4'd1;
        bits_now = field[31:16];

        if (accept && !r_failed) begin
            n_field = field;
            case (r_phase)
                PhRiff, PhRsize, PhWave, PhId: begin
                    n_pos = pos_inc;
                    if (pos_inc == 4'd4) begin
                        n_pos = 4'd0;
                        case (r_phase)
                            PhRiff: begin
                                if (field != TagRiff) begin
                                    v_c = 1'b1; res_c = mk_error(ErrNoRiff, i_in.is_final);
                                    n_failed = 1'b1; n_err = ErrNoRiff;
                                end else begin
                                    n_phase = PhRsize;
                                end
                            end
                            PhRsize: n_phase = PhWave;
                            PhWave: begin
                                if (field != TagWave) begin
                                    v_c = 1'b1; res_c = mk_error(ErrNoWave, i_in.is_final);
                                    n_failed = 1'b1; n_err = ErrNoWave;
                                end else begin
                                    n_phase = PhId;
                                end
                            end
                            default: begin
                                n_tag   = field;
                                n_phase = PhSize;
                            end
                        endcase
                    end
                end
                PhSize: begin
                    n_pos = pos_inc;
                    if (pos_inc == 4'd4) begin
                        n_pos  = 4'd0;
                        n_left = field;
                        if (r_tag == TagFmt) begin
                            if (field < FmtMin) begin
                                v_c = 1'b1; res_c = mk_error(ErrFmtShort, i_in.is_final);
                                n_failed = 1'b1; n_err = ErrFmtShort;
                            end else begin
                                n_phase = PhFmt;
                            end
                        end else if (r_tag == TagData) begin
                            if (!r_fmt_done) begin
                                v_c = 1'b1; res_c = mk_error(ErrDataEarly, i_in.is_final);
                                n_failed = 1'b1; n_err = ErrDataEarly;
                            end else begin
                                n_phase = (field != 32'd0) ? PhData : PhId;
                            end
                        end else begin
                            n_phase = (field != 32'd0) ? PhSkip : PhId;
                        end
                    end
                end
                PhFmt: begin
                    n_left = left_dec;
                    n_pos  = pos_inc;
                    case (r_pos)
                        4'd1:    n_fmt   = field[31:16];
                        4'd3:    n_ch    = field[31:16];
                        4'd7:    n_rate  = field;
                        4'd13:   n_align = field[31:16];
                        4'd15:   n_bits  = bits_now;
                        default: ;
                    endcase
                    // The sixteenth field byte closes the fixed part of fmt.
                    if (r_pos == 4'd15) begin
                        n_pos = 4'd0;
                        if (r_fmt != PcmFormat) begin
                            v_c = 1'b1; res_c = mk_error(ErrNotPcm, i_in.is_final);
                            n_failed = 1'b1; n_err = ErrNotPcm;
                        end else if (bits_now != PcmBits) begin
                            v_c = 1'b1; res_c = mk_error(ErrNot16, i_in.is_final);
                            n_failed = 1'b1; n_err = ErrNot16;
                        end else if (r_align == 16'd0 || r_ch == 16'd0) begin
                            v_c = 1'b1; res_c = mk_error(ErrBadFmt, i_in.is_final);
                            n_failed = 1'b1; n_err = ErrBadFmt;
                        end else begin
                            n_fmt_done = 1'b1;
                            v_c = 1'b1; res_c = mk_format(r_rate, r_ch);
                            n_phase = (left_dec != 32'd0) ? PhSkip : PhId;
                        end
                    end
                end
                PhSkip: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) n_phase = PhId;
                end
                default: begin
                    n_left = left_dec;
                    if (r_pos == 4'd0) begin
                        n_low = i_in.data_byte;
                        n_pos = 4'd1;
                    end else begin
                        n_pos = 4'd0;
                        n_any = 1'b1;
                        v_c = 1'b1; res_c = mk_sample({i_in.data_byte, r_low});
                    end
                    if (left_dec == 32'd0) begin
                        n_pos   = 4'd0;
                        n_phase = PhId;
                    end
                end
            endcase
        end

        if (accept && i_in.is_final) begin
            if (n_failed) begin
                // A fresh error on the final byte already carries the final flag.
                if (r_failed) begin
                    v_f = 1'b1; res_f = mk_error(r_err, 1'b1);
                end
            end else begin
                case (n_phase)
                    PhRiff: end_code = ErrNoRiff;
                    PhWave: end_code = ErrNoWave;
                    PhId, PhSkip: begin
                        ok = n_fmt_done && n_any;
                        end_code = ErrMissing;
                    end
                    default: end_code = ErrTruncated;
                endcase
                v_f = 1'b1;
                res_f = ok ? mk_finish() : mk_error(end_code, 1'b1);
            end
            n_phase = PhRiff;  n_field = '0;  n_left = '0;  n_tag = '0;
            n_fmt = '0;  n_ch = '0;  n_rate = '0;  n_bits = '0;  n_align = '0;
            n_fmt_done = 1'b0;  n_any = 1'b0;  n_low = '0;
            n_failed = 1'b0;  n_pos = '0;  n_err = '0;
        end
    end

    always_comb begin
        o_push      = accept && (v_c || v_f);
        o_pair.cnt  = {1'b0, v_c} + {1'b0, v_f};
        o_pair.r0   = v_c ? res_c : res_f;
        o_pair.r1   = res_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhRiff;  r_field <= '0;  r_left <= '0;  r_tag <= '0;
            r_fmt <= '0;  r_ch <= '0;  r_rate <= '0;  r_bits <= '0;  r_align <= '0;
            r_fmt_done <= 1'b0;  r_any <= 1'b0;  r_low <= '0;
            r_failed <= 1'b0;  r_pos <= '0;  r_err <= '0;
        end else begin
            r_phase <= n_phase;  r_field <= n_field;  r_left <= n_left;  r_tag <= n_tag;
            r_fmt <= n_fmt;  r_ch <= n_ch;  r_rate <= n_rate;  r_bits <= n_bits;
            r_align <= n_align;  r_fmt_done <= n_fmt_done;  r_any <= n_any;
            r_low <= n_low;  r_failed <= n_failed;  r_pos <= n_pos;  r_err <= n_err;
        end
    end

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.is_final) |=> (r_phase == PhRiff && !r_failed && r_pos == 4'd0))
        else $error("parser state not cleared after final byte");

    a_failed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_failed && !i_in.is_final) |-> !o_push)
        else $error("result pushed while parser is in error");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PhFmt) |-> (r_pos < 4'd4))
        else $error("byte position out of range for phase");

endmodule

// File: design/rwp_queue.sv
// Small register queue of result pairs between the parser and the output stage.
module rwp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rwp_pkg::t_pair i_pair,
    input  logic           i_pop,
    output logic           o_full,
    output rwp_pkg::t_head o_head
);
    import rwp_pkg::*;

    t_pair              r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr, r_rd;
    logic [QCntW-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full      = (r_cnt == QCntW'(QDepth));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.pair  = r_mem[r_rd];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + QPtrW'(1);
            if (do_pop)  r_rd <= r_rd + QPtrW'(1);
            r_cnt <= r_cnt + QCntW'(do_push) - QCntW'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCntW'(QDepth))
        else $error("queue count exceeds depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("pair pushed into a full queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + QCntW'(1)))
        else $error("queue count did not follow a push");

endmodule

// File: design/rwp_back.sv
// Back end: splits queued pairs into single results behind an output register.
module rwp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rwp_pkg::t_head i_head,
    output logic           o_pop,
    rwp_out_if.source      o_out
);
    import rwp_pkg::*;

    logic    r_valid, n_valid;
    logic    r_half, n_half;
    t_result r_res, n_res;

    always_comb begin
        logic load;
        logic last;

        n_valid = r_valid;
        n_half  = r_half;
        n_res   = r_res;
        o_pop   = 1'b0;
        load    = !r_valid || o_out.ready;
        last    = r_half || (i_head.pair.cnt == 2'd1);

        if (load) begin
            n_valid = i_head.valid;
            if (i_head.valid) begin
                n_res  = r_half ? i_head.pair.r1 : i_head.pair.r0;
                o_pop  = last;
                n_half = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out.valid         = r_valid;
    assign o_out.event_kind    = r_res.kind;
    assign o_out.sample_value  = r_res.sample;
    assign o_out.rate_hz       = r_res.rate;
    assign o_out.channel_total = r_res.chans;
    assign o_out.error_code    = r_res.err;
    assign o_out.final_result  = r_res.fin;

endmodule

// File: design/riff_wav_stream_parser_top.sv
// Top level of the RIFF/WAVE 16-bit PCM stream parser.
// The block takes one file byte per beat and can accept a byte in every clock cycle: the
// chunk parser in the front end finishes each byte in the cycle it is accepted. A byte
// causes at most two result beats (the second only on the final byte), which wait in a
// four-entry pair queue and leave through a registered output at one beat per cycle
// while the output is ready. Input ready drops only while the pair queue is full because
// the output side is stalled. An error is reported once and then held until the final
// byte, which repeats it unless it arose on that byte; the final byte always closes the
// file with a result flagged final_result.
module riff_wav_stream_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rwp_in_if.sink    i_in,
    rwp_out_if.source o_out
);
    import rwp_pkg::*;

    logic  full;
    logic  push;
    logic  pop;
    t_pair pair;
    t_head head;

    rwp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_pair  (pair)
    );

    rwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (pair),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    rwp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: tb/tb_riff_wav_stream_parser_top.sv
// Self-checking testbench for the RIFF/WAVE stream parser: random WAV files in, predicted events out.
module tb_riff_wav_stream_parser_top;
    import rwp_pkg::*;

    localparam int CycleLimit  = 1_000_000;
    localparam int TargetBytes = 1350;
    localparam int DrainCycles = 8;
    localparam int MaxReports  = 40;

    localparam logic [7:0] TagLen        = 8'd4;
    localparam logic [7:0] FmtFieldBytes = 8'd16;
    localparam logic [7:0] OffFormat     = 8'd1;
    localparam logic [7:0] OffChannels   = 8'd3;
    localparam logic [7:0] OffRate       = 8'd7;
    localparam logic [7:0] OffAlign      = 8'd13;
    localparam logic [7:0] OffBits       = 8'd15;

    typedef enum logic [3:0] {
        StRiff, StRiffSize, StWave, StChunkId, StChunkSize, StFmtBody, StSkip, StData
    } t_parse_state;

    typedef enum int {
        ScClean, ScTruncate, ScCorrupt, ScBadFormat, ScBadBits, ScNoChannels, ScNoAlign,
        ScShortFmt, ScDataEarly, ScNoData, ScNoSamples, ScEndInSkip, ScEndInId, ScHugeData,
        ScRepeatFmt, ScNoise
    } t_file_shape;

    localparam int ShapeCount = int'(ScNoise) + 1;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       hold;
    } t_stream_byte;

    logic i_clk;
    logic i_rst_n;

    rwp_in_if  in_if();
    rwp_out_if out_if();

    riff_wav_stream_parser_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Parser state mirrored by the predictor.
    t_parse_state ps;
    logic [31:0]  field_sr;
    logic [31:0]  left_cnt;
    logic [31:0]  cur_tag;
    logic [15:0]  fmt_code;
    logic [15:0]  chans_q;
    logic [31:0]  rate_q;
    logic [15:0]  bits_q;
    logic [15:0]  align_q;
    logic         fmt_ok;
    logic         got_sample;
    logic [7:0]   low_byte;
    logic         err_latched;
    logic [7:0]   byte_pos;
    logic [3:0]   err_held;

    t_result      expected_events[$];
    t_stream_byte byte_q[$];
    logic [7:0]   file_buf[$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    logic drained     = 1'b1;

    task automatic wav_reset_model();
        ps          = StRiff;
        field_sr    = '0;
        left_cnt    = '0;
        cur_tag     = '0;
        fmt_code    = '0;
        chans_q     = '0;
        rate_q      = '0;
        bits_q      = '0;
        align_q     = '0;
        fmt_ok      = 1'b0;
        got_sample  = 1'b0;
        low_byte    = '0;
        err_latched = 1'b0;
        byte_pos    = '0;
        err_held    = '0;
    endtask

    task automatic push_event(input logic [1:0] kind, input logic [15:0] smp,
                              input logic [31:0] rate, input logic [15:0] chans,
                              input logic [3:0] code, input logic fin);
        t_result r;
        r        = '0;
        r.kind   = kind;
        r.sample = smp;
        r.rate   = rate;
        r.chans  = chans;
        r.err    = code;
        r.fin    = fin;
        expected_events.push_back(r);
    endtask

    task automatic flag_error(input logic [3:0] code, input logic fin);
        err_latched = 1'b1;
        err_held    = code;
        push_event(KindError, '0, '0, '0, code, fin);
    endtask

    task automatic wav_consume(input logic [7:0] b, input logic fin);
        field_sr = {b, field_sr[31:8]};
        case (ps)
            StRiff, StRiffSize, StWave, StChunkId: begin
                byte_pos = byte_pos + 8'd1;
                if (byte_pos == TagLen) begin
                    byte_pos = '0;
                    case (ps)
                        StRiff: begin
                            if (field_sr != TagRiff) flag_error(ErrNoRiff, fin);
                            else ps = StRiffSize;
                        end
                        StRiffSize: ps = StWave;
                        StWave: begin
                            if (field_sr != TagWave) flag_error(ErrNoWave, fin);
                            else ps = StChunkId;
                        end
                        default: begin
                            cur_tag = field_sr;
                            ps      = StChunkSize;
                        end
                    endcase
                end
            end
            StChunkSize: begin
                byte_pos = byte_pos + 8'd1;
                if (byte_pos == TagLen) begin
                    byte_pos = '0;
                    left_cnt = field_sr;
                    if (cur_tag == TagFmt) begin
                        if (left_cnt < FmtMin) flag_error(ErrFmtShort, fin);
                        else ps = StFmtBody;
                    end else if (cur_tag == TagData) begin
                        if (!fmt_ok) flag_error(ErrDataEarly, fin);
                        else ps = (left_cnt != 32'd0) ? StData : StChunkId;
                    end else begin
                        ps = (left_cnt != 32'd0) ? StSkip : StChunkId;
                    end
                end
            end
            StFmtBody: begin
                left_cnt = left_cnt - 32'd1;
                case (byte_pos)
                    OffFormat:   fmt_code = field_sr[31:16];
                    OffChannels: chans_q  = field_sr[31:16];
                    OffRate:     rate_q   = field_sr;
                    OffAlign:    align_q  = field_sr[31:16];
                    OffBits:     bits_q   = field_sr[31:16];
                    default: ;
                endcase
                byte_pos = byte_pos + 8'd1;
                if (byte_pos == FmtFieldBytes) begin
                    byte_pos = '0;
                    if (fmt_code != PcmFormat) flag_error(ErrNotPcm, fin);
                    else if (bits_q != PcmBits) flag_error(ErrNot16, fin);
                    else if (align_q == 16'd0 || chans_q == 16'd0) flag_error(ErrBadFmt, fin);
                    else begin
                        fmt_ok = 1'b1;
                        push_event(KindFormat, '0, rate_q, chans_q, '0, 1'b0);
                        ps = (left_cnt != 32'd0) ? StSkip : StChunkId;
                    end
                end
            end
            StSkip: begin
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 32'd0) ps = StChunkId;
            end
            StData: begin
                left_cnt = left_cnt - 32'd1;
                if (byte_pos == 8'd0) begin
                    low_byte = b;
                    byte_pos = 8'd1;
                end else begin
                    byte_pos   = '0;
                    got_sample = 1'b1;
                    push_event(KindSample, {b, low_byte}, '0, '0, '0, 1'b0);
                end
                // An unpaired last byte of the chunk is simply dropped.
                if (left_cnt == 32'd0) begin
                    byte_pos = '0;
                    ps       = StChunkId;
                end
            end
            default: ;
        endcase
    endtask

    // Computes the events caused by one accepted byte and queues them.
    task automatic wav_step(input logic [7:0] b, input logic fin);
        logic       was_failed;
        logic       ok;
        logic [3:0] code;
        was_failed = err_latched;
        ok         = 1'b0;
        if (!err_latched) wav_consume(b, fin);
        if (fin) begin
            if (err_latched) begin
                // An error found on this very byte was already reported as final.
                if (was_failed) push_event(KindError, '0, '0, '0, err_held, 1'b1);
            end else begin
                case (ps)
                    StRiff: code = ErrNoRiff;
                    StWave: code = ErrNoWave;
                    StChunkId, StSkip: begin
                        ok   = fmt_ok && got_sample;
                        code = ErrMissing;
                    end
                    default: code = ErrTruncated;
                endcase
                if (ok) push_event(KindFinish, '0, '0, '0, '0, 1'b1);
                else push_event(KindError, '0, '0, '0, code, 1'b1);
            end
            wav_reset_model();
        end
    endtask

    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Periodic windows in which a side draws no new idle gap.
    function automatic bit calm_phase(input int shift);
        return ((cycle_count >> shift) & 3) == 0;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic put_u8(input logic [7:0] v);
        file_buf.push_back(v);
    endtask

    task automatic put_u16(input logic [15:0] v);
        put_u8(v[7:0]);
        put_u8(v[15:8]);
    endtask

    task automatic put_u32(input logic [31:0] v);
        put_u16(v[15:0]);
        put_u16(v[31:16]);
    endtask

    task automatic put_bytes(input int n);
        for (int i = 0; i < n; i++) put_u8(rand_byte());
    endtask

    task automatic put_fmt(input logic [31:0] size, input logic [15:0] format,
                           input logic [15:0] chans, input logic [15:0] align,
                           input logic [15:0] bits, input logic [31:0] rate);
        put_u32(TagFmt);
        put_u32(size);
        put_u16(format);
        put_u16(chans);
        put_u32(rate);
        put_u32($urandom);
        put_u16(align);
        put_u16(bits);
        if (size > FmtMin && size <= 32'd40) put_bytes(size - FmtMin);
    endtask

    task automatic put_data(input int n);
        put_u32(TagData);
        put_u32(n);
        put_bytes(n);
    endtask

    task automatic put_other_chunk(input int n);
        put_u32($urandom);
        put_u32(n);
        put_bytes(n);
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Moves the assembled file into the send queue, flagging its last byte and, with hold set, its first byte as held.
    task automatic commit_file(input bit hold);
        t_stream_byte e;
        for (int i = 0; i < file_buf.size(); i++) begin
            e.value = file_buf[i];
            e.last  = (i == file_buf.size() - 1);
            e.hold  = hold && (i == 0);
            byte_q.push_back(e);
        end
        file_buf.delete();
    endtask

    task automatic build_wav(input t_file_shape shape);
        logic [15:0] f_format;
        logic [15:0] f_chans;
        logic [15:0] f_align;
        logic [15:0] f_bits;
        logic [31:0] f_size;
        int          n_chunks;
        int          cut;
        f_format = PcmFormat;
        f_bits   = PcmBits;
        f_chans  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8));
        f_align  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'(f_chans * 2);
        f_size   = ($urandom_range(0, 1) == 0) ? FmtMin : FmtMin + $urandom_range(1, 4);
        case (shape)
            ScBadFormat: begin
                f_format = 16'($urandom);
                if (f_format == PcmFormat) f_format = 16'd3;
            end
            ScBadBits: begin
                f_bits = 16'($urandom);
                if (f_bits == PcmBits) f_bits = 16'd8;
            end
            ScNoChannels: f_chans = '0;
            ScNoAlign:    f_align = '0;
            ScShortFmt:   f_size  = $urandom_range(0, 15);
            default: ;
        endcase
        if (shape == ScNoise) begin
            put_bytes($urandom_range(1, 20));
        end else begin
            put_u32(TagRiff);
            put_u32($urandom);
            put_u32(TagWave);
            if (shape == ScDataEarly) put_data($urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0) put_other_chunk($urandom_range(0, 6));
            put_fmt(f_size, f_format, f_chans, f_align, f_bits, pick_rate());
            if (shape != ScNoData) begin
                n_chunks = $urandom_range(1, 3);
                for (int i = 0; i < n_chunks; i++) begin
                    if ($urandom_range(0, 3) == 0) put_other_chunk($urandom_range(0, 6));
                    if (shape == ScRepeatFmt)
                        put_fmt(FmtMin, PcmFormat, f_chans, f_align, PcmBits, pick_rate());
                    if (shape == ScNoSamples) put_data($urandom_range(0, 1));
                    else put_data($urandom_range(0, 24));
                end
            end
            case (shape)
                ScEndInSkip: begin
                    put_u32($urandom);
                    put_u32($urandom_range(8, 100000));
                    put_bytes($urandom_range(0, 6));
                end
                ScEndInId: put_bytes($urandom_range(1, 3));
                ScHugeData: begin
                    put_u32(TagData);
                    put_u32(32'hFFFF_FFFF - $urandom_range(0, 3));
                    put_bytes($urandom_range(0, 9));
                end
                ScTruncate: begin
                    cut = $urandom_range(1, file_buf.size());
                    while (file_buf.size() > cut) void'(file_buf.pop_back());
                end
                ScCorrupt: file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
                default: ;
            endcase
        end
    endtask

    task automatic report_field(input string name, input logic signed [63:0] want_v,
                                input logic signed [63:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            if (fail_count <= MaxReports)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Byte driver: sends queued bytes when the slot is free, after idle gaps; held bytes wait for a full drain.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= '0;
            in_if.is_final  <= 1'b0;
            gap_left = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (byte_q.size() > 0 && !(byte_q[0].hold && (in_if.valid || !drained))) begin
                in_if.valid     <= 1'b1;
                in_if.data_byte <= byte_q[0].value;
                in_if.is_final  <= byte_q[0].last;
                void'(byte_q.pop_front());
                gap_left = calm_phase(8) ? 0 : pick_delay();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = calm_phase(9) ? 0 : pick_delay();
        end
    end

    // Monitor: predicts on every accepted byte and checks every accepted result beat.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) wav_step(in_if.data_byte, in_if.is_final);
            if (out_if.valid && out_if.ready) begin
                if (expected_events.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MaxReports)
                        $display("%0t: unexpected result, expected none, got kind %0d",
                                 $time, out_if.event_kind);
                end else begin
                    want = expected_events.pop_front();
                    report_field("event_kind", 64'(want.kind), 64'(out_if.event_kind));
                    report_field("sample_value", 64'(want.sample), 64'(out_if.sample_value));
                    report_field("rate_hz", 64'(want.rate), 64'(out_if.rate_hz));
                    report_field("channel_total", 64'(want.chans), 64'(out_if.channel_total));
                    report_field("error_code", 64'(want.err), 64'(out_if.error_code));
                    report_field("final_result", 64'(want.fin), 64'(out_if.final_result));
                end
            end
        end
        drained <= (expected_events.size() == 0);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb_riff_wav_stream_parser_top: FAIL");
            $finish;
        end
    end

    initial begin
        int          k;
        t_file_shape shape;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.is_final  = 1'b0;
        out_if.ready    = 1'b0;
        wav_reset_model();

        // Short files that end inside the headers, with and without a bad tag.
        put_u8(8'h52);
        commit_file(1'b0);
        put_u32(32'h5846_4952);
        put_u8(8'hFF);
        commit_file(1'b0);
        put_u32(32'h5846_4952);
        commit_file(1'b0);
        put_u32(TagRiff);
        put_u8(8'h00);
        put_u8(8'hFF);
        commit_file(1'b0);
        put_u32(TagRiff);
        put_u32(32'hFFFF_FFFF);
        put_u8(8'h57);
        put_u8(8'h41);
        commit_file(1'b0);

        // Every file shape once, then clean files 35 percent of the time and the other shapes otherwise.
        k = 0;
        while (byte_q.size() < TargetBytes) begin
            if (k < ShapeCount) shape = t_file_shape'(k);
            else if ($urandom_range(0, 99) < 35) shape = ScClean;
            else shape = t_file_shape'($urandom_range(1, ShapeCount - 1));
            build_wav(shape);
            commit_file(k % 6 == 4);
            k++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_riff_wav_stream_parser_top: PASS");
        end else begin
            $display("tb_riff_wav_stream_parser_top: FAIL");
        end
        $finish;
    end

endmodule

// File: riff_wav_stream_parser_top.f
design/rwp_pkg.sv
design/rwp_in_if.sv
design/rwp_out_if.sv
design/rwp_front.sv
design/rwp_queue.sv
design/rwp_back.sv
design/riff_wav_stream_parser_top.sv
tb/tb_riff_wav_stream_parser_top.sv
